### rtl/core/throttle_curve_interpolator_top_assert.svh
// ----------------------------------------------------------------------------
// Throttle curve interpolator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef THROTTLE_CURVE_INTERPOLATOR_TOP_ASSERT_SVH
`define THROTTLE_CURVE_INTERPOLATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TCI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TCI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tci_pkg.sv
// ----------------------------------------------------------------------------
// Throttle curve interpolator package
// Widths, command codes and the fixed throttle curve table.
// ----------------------------------------------------------------------------
package tci_pkg;

   localparam int CURVE_POINTS = 11;
   localparam int CURVE_COUNT  = 4;

   localparam int PEDAL_W     = 9;
   localparam int DRIVE_W     = 12;
   localparam int CURVE_SEL_W = 2;
   localparam int SEG_W       = $clog2(CURVE_POINTS);
   localparam int Y_W         = 19;
   localparam int PSCALED_W   = 12;
   localparam int DELTA_W     = 9;
   localparam int RECIP_W     = 20;
   localparam int RECIP_SHIFT = 26;
   localparam int QUOT_W      = Y_W + RECIP_W - RECIP_SHIFT;

   localparam logic CMD_CONVERT    = 1'b0;
   localparam logic CMD_NEXT_CURVE = 1'b1;

   localparam logic [PEDAL_W-1:0]     PEDAL_FULL = 9'd256;
   localparam logic [DRIVE_W-1:0]     DRIVE_MAX  = 12'd4095;
   localparam logic [CURVE_SEL_W-1:0] CURVE_LAST = CURVE_SEL_W'(CURVE_COUNT - 1);

   // ceil(2^26 / 100); exact floor division by 100 for all values below 2^19.
   localparam logic [RECIP_W-1:0] RECIP_100 = 20'd671089;

   // Curve values in hundredths of a drive unit, curves A to D.
   localparam logic [Y_W-1:0] CURVE_TAB [CURVE_COUNT][CURVE_POINTS] = '{
      '{19'd0,      19'd40960,  19'd81920,  19'd122880, 19'd163840, 19'd204800,
        19'd245760, 19'd286720, 19'd327680, 19'd368640, 19'd409600},
      '{19'd122880, 19'd151552, 19'd180224, 19'd208896, 19'd237568, 19'd266240,
        19'd294912, 19'd323584, 19'd352256, 19'd380928, 19'd409600},
      '{19'd61440,  19'd81920,  19'd102400, 19'd122880, 19'd163840, 19'd204800,
        19'd245760, 19'd286720, 19'd327680, 19'd368640, 19'd409600},
      '{19'd0,      19'd10240,  19'd30720,  19'd51200,  19'd81920,  19'd122880,
        19'd163840, 19'd204800, 19'd245760, 19'd307200, 19'd409600}
   };

endpackage

### rtl/core/tci_req_if.sv
// ----------------------------------------------------------------------------
// Throttle curve interpolator request channel
// Valid/ready channel carrying one command and one pedal reading per item.
// ----------------------------------------------------------------------------
interface tci_req_if import tci_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [PEDAL_W-1:0] pedal_level;

   modport source (output valid, output cmd, output pedal_level, input ready);
   modport sink   (input valid, input cmd, input pedal_level, output ready);
endinterface

### rtl/core/tci_rsp_if.sv
// ----------------------------------------------------------------------------
// Throttle curve interpolator response channel
// Valid/ready channel carrying one drive level and the active curve per item.
// ----------------------------------------------------------------------------
interface tci_rsp_if import tci_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DRIVE_W-1:0]     drive_level;
   logic [CURVE_SEL_W-1:0] curve_index;

   modport source (output valid, output drive_level, output curve_index, input ready);
   modport sink   (input valid, input drive_level, input curve_index, output ready);
endinterface

### rtl/core/tci_seg_mul.sv
// ----------------------------------------------------------------------------
// Throttle curve segment interpolation
// Finds the curve segment for a pedal reading and forms the interpolation
// numerator, already divided by 256.
// ----------------------------------------------------------------------------
module tci_seg_mul import tci_pkg::*; (
   input  logic [CURVE_SEL_W-1:0] curve_sel,
   input  logic [PEDAL_W-1:0]     pedal_level,
   output logic [Y_W-1:0]         num_hi
);

   logic [PEDAL_W-1:0]     pedal_clamp;
   logic [PSCALED_W-1:0]   pscaled;
   logic [PSCALED_W-1:0]   pround;
   logic [SEG_W-1:0]       seg;
   logic [SEG_W-1:0]       seg_lo;
   logic [PSCALED_W-1:0]   upper_x;
   logic [PSCALED_W-1:0]   delta_full;
   logic [DELTA_W-1:0]     delta;
   logic [Y_W-1:0]         y0;
   logic [Y_W-1:0]         y1;
   logic [Y_W-1:0]         dy;
   logic [Y_W+DELTA_W-1:0] prod;
   logic [Y_W+7:0]         num;

   always_comb begin
      pedal_clamp = (pedal_level > PEDAL_FULL) ? PEDAL_FULL : pedal_level;
      // Pedal times ten, so breakpoints land on multiples of 256.
      pscaled = {pedal_clamp, 3'b000} + {2'b00, pedal_clamp, 1'b0};
      // The upper breakpoint is the ceiling of pscaled / 256, at least one.
      pround = pscaled + PSCALED_W'(255);
      seg    = pround[PSCALED_W-1:8];
      if (seg == '0) begin
         seg = SEG_W'(1);
      end
      seg_lo = seg - SEG_W'(1);

      upper_x    = {seg, 8'h00};
      delta_full = upper_x - pscaled;
      delta      = delta_full[DELTA_W-1:0];

      y0 = CURVE_TAB[curve_sel][seg_lo];
      y1 = CURVE_TAB[curve_sel][seg];
      dy = y1 - y0;

      // The curves rise, so 256*y1 - delta*dy never drops below 256*y0.
      prod   = delta * dy;
      num    = {y1, 8'h00} - prod[Y_W+7:0];
      num_hi = num[Y_W+7:8];
   end

endmodule

### rtl/core/throttle_curve_interpolator_top.sv
// ----------------------------------------------------------------------------
// Throttle curve interpolator
// Maps a pedal reading to a 12-bit drive level through one of four throttle
// curves; a map-change item steps the curve A, B, C, D and back to A.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the response side is ready, and
// presents each result from the result register. The three stages are the
// input register, a register after the segment lookup and interpolation
// multiply, and the result register after the divide-by-100 reciprocal
// multiply; these two multipliers set the depth. A stalled response fills the
// empty stages before the request side sees ready drop. The curve selection
// changes when a map-change item is accepted, and every result reports the
// curve in use after its item; map-change results carry a drive level of zero.
module throttle_curve_interpolator_top import tci_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   tci_req_if.sink   req,
   tci_rsp_if.source rsp
);

`include "throttle_curve_interpolator_top_assert.svh"

   logic [CURVE_SEL_W-1:0] curve_sel_ff;
   logic [CURVE_SEL_W-1:0] curve_sel_in;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   logic                   s1_cmd_ff;
   logic [CURVE_SEL_W-1:0] s1_curve_ff;
   logic [PEDAL_W-1:0]     s1_pedal_ff;

   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   logic                   s2_cmd_ff;
   logic [CURVE_SEL_W-1:0] s2_curve_ff;
   logic [Y_W-1:0]         s2_num_ff;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [DRIVE_W-1:0]     out_drive_ff;
   logic [DRIVE_W-1:0]     out_drive_in;
   logic [CURVE_SEL_W-1:0] out_curve_ff;

   logic                   s1_load;
   logic                   s2_load;
   logic                   out_load;
   logic                   req_fire;
   logic [Y_W-1:0]         num_hi;
   logic [Y_W+RECIP_W-1:0] recip_prod;
   logic [QUOT_W-1:0]      quot;

   // A stage may load when it is empty or its content moves on this cycle.
   assign out_load  = !out_valid_ff || rsp.ready;
   assign s2_load   = !s2_valid_ff || out_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req.ready = s1_load;
   assign req_fire  = req.valid && s1_load;

   always_comb begin
      curve_sel_in = curve_sel_ff;
      if (req_fire && (req.cmd == CMD_NEXT_CURVE)) begin
         curve_sel_in = (curve_sel_ff == CURVE_LAST) ? '0 : curve_sel_ff + CURVE_SEL_W'(1);
      end
   end

   assign s1_valid_in  = s1_load ? req.valid : s1_valid_ff;
   assign s2_valid_in  = s2_load ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_load ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_sel_ff <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         curve_sel_ff <= curve_sel_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   tci_seg_mul u_seg_mul (
      .curve_sel   (s1_curve_ff),
      .pedal_level (s1_pedal_ff),
      .num_hi      (num_hi)
   );

   // Floor division by 100 through the reciprocal, then saturation; map-change items give zero.
   always_comb begin
      recip_prod = s2_num_ff * RECIP_100;
      quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
      if (s2_cmd_ff == CMD_NEXT_CURVE) begin
         out_drive_in = '0;
      end else if (quot > QUOT_W'(DRIVE_MAX)) begin
         out_drive_in = DRIVE_MAX;
      end else begin
         out_drive_in = quot[DRIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff   <= req.cmd;
         s1_curve_ff <= curve_sel_in;
         s1_pedal_ff <= req.pedal_level;
      end
      if (s2_load && s1_valid_ff) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_curve_ff <= s1_curve_ff;
         s2_num_ff   <= num_hi;
      end
      if (out_load && s2_valid_ff) begin
         out_drive_ff <= out_drive_in;
         out_curve_ff <= s2_curve_ff;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.drive_level = out_drive_ff;
   assign rsp.curve_index = out_curve_ff;

   `TCI_ASSERT_NEXT(a_map_change_zero_drive, clock, reset,
      s2_valid_ff && out_load && (s2_cmd_ff == CMD_NEXT_CURVE),
      rsp.drive_level == '0, "map-change result carries a nonzero drive level")
   `TCI_ASSERT_NEXT(a_curve_only_on_change, clock, reset,
      !(req_fire && (req.cmd == CMD_NEXT_CURVE)),
      $stable(curve_sel_ff), "curve selection moved without a map-change item")
   `TCI_ASSERT_NOW(a_ready_needs_room, clock, reset,
      req.ready && rsp.valid && !rsp.ready,
      !(s1_valid_ff && s2_valid_ff), "request ready while the pipeline is full")

endmodule
